// File: design/tca_pkg.sv
// shared types and constants for the trade candle aggregator
// no dependencies; imported by tca_remainder, tca_candle_store and trade_candle_aggregator
package tca_pkg;

    // field widths
    localparam int TS_W     = 64;
    localparam int PRICE_W  = 64;
    localparam int QTY_W    = 32;
    localparam int VOL_W    = 64;
    localparam int COUNT_W  = 32;
    localparam int PMS_W    = 27;
    localparam int PER_W    = 47;
    localparam int NSMS_W   = 20;
    localparam int STEP_W   = 7;

    localparam logic [PMS_W-1:0]   PERIOD_MS_RESET = 27'd1000;
    localparam logic [NSMS_W-1:0]  NS_PER_MS       = 20'd1000000;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
    localparam logic [STEP_W-1:0]  DIV_STEPS       = 7'd64;

    // input item opcodes
    localparam logic OP_TRADE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT,
        ST_DIV,
        ST_UPDATE
    } state_t;

    // commands to the candle store
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_TRADE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [TS_W-1:0]     clear_start;
        logic [PRICE_W-1:0]  price;
        logic [QTY_W-1:0]    qty;
    } candle_cmd_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [VOL_W-1:0]    volume;
        logic [PRICE_W-1:0]  close_p;
        logic [PRICE_W-1:0]  low_p;
        logic [PRICE_W-1:0]  high_p;
        logic [PRICE_W-1:0]  open_p;
        logic [TS_W-1:0]     start;
    } candle_t;

endpackage

// File: design/tca_remainder.sv
// iterative restoring remainder unit, one shift-subtract step per cycle
// depends on tca_pkg
module tca_remainder
    import tca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [TS_W-1:0]  dividend,
    input  logic [PER_W-1:0] divisor,
    output logic             done,
    output logic [PER_W-1:0] remainder
);

    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [TS_W-1:0]   dvd_reg, dvd_next;
    logic [PER_W-1:0]  dvs_reg, dvs_next;
    logic [PER_W-1:0]  rem_reg, rem_next;
    logic [PER_W:0]    trial;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    // shared compare and subtract step
    assign trial = {rem_reg, dvd_reg[TS_W-1]};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            cnt_next = DIV_STEPS;
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dvd_next = {dvd_reg[TS_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = PER_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[PER_W-1:0];
            end
            if (cnt_reg == 7'd1)
            begin
                done_next = 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: design/tca_candle_store.sv
// open candle registers: open, high, low, close, volume, count and start
// depends on tca_pkg
module tca_candle_store
    import tca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  candle_cmd_t cmd,
    output candle_t     candle
);

    candle_t cur_reg, cur_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else
        begin
            cur_reg <= cur_next;
        end
    end

    // apply clear or trade command
    always_comb
    begin
        cur_next = cur_reg;
        unique case (cmd.kind)
            CMD_CLEAR:
            begin
                cur_next       = '0;
                cur_next.start = cmd.clear_start;
            end
            CMD_TRADE:
            begin
                if (cur_reg.count == '0)
                begin
                    cur_next.open_p = cmd.price;
                    cur_next.high_p = cmd.price;
                    cur_next.low_p  = cmd.price;
                end
                else
                begin
                    if (cmd.price > cur_reg.high_p)
                    begin
                        cur_next.high_p = cmd.price;
                    end
                    if (cmd.price < cur_reg.low_p)
                    begin
                        cur_next.low_p = cmd.price;
                    end
                end
                cur_next.close_p = cmd.price;
                cur_next.volume  = cur_reg.volume + VOL_W'(cmd.qty);
                if (cur_reg.count != COUNT_MAX)
                begin
                    cur_next.count = cur_reg.count + 1'b1;
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase
    end

    assign candle = cur_reg;

endmodule

// File: design/trade_candle_aggregator.sv
// trade_candle_aggregator: a trade that stays within the open candle passes
// through accept, period check and update before the next ready. A trade that
// opens a candle (the first after reset, or one at or past the candle start
// plus the period) first emits the finished candle if it holds trades, waiting
// for a free output register, then finds the aligned start with a shared
// 64-step shift-subtract remainder unit, one bit per cycle. A flush emits the
// open candle if it holds trades and clears it. A finished candle is held in
// an output register; the block keeps accepting while it waits and stalls only
// when a second candle must be emitted before the first is taken. period_ms is
// taken on the next accepted item; zero acts as one millisecond.
// depends on tca_pkg, tca_remainder, tca_candle_store
module trade_candle_aggregator
    import tca_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [PMS_W-1:0]     cfg_wr_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // timestamp_ns, price_raw, quantity
    input  logic [159:0]         s_tdata,
    // op
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // candle_start_ns, open_price, high_price, low_price, close_price,
    // total_volume, trades_in_candle
    output logic [415:0]         m_tdata
);

    state_t             state_reg, state_next;
    logic [PMS_W-1:0]   period_ms_reg;
    logic               started_reg, started_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [415:0]       m_tdata_reg, m_tdata_next;
    logic               op_reg;
    logic [TS_W-1:0]    ts_reg;
    logic [PRICE_W-1:0] price_reg;
    logic [QTY_W-1:0]   qty_reg;
    logic [PER_W-1:0]   per_reg;
    logic [PMS_W-1:0]   pms_eff;
    logic [PER_W-1:0]   per_calc;
    logic [TS_W-1:0]    ts_diff;
    logic               new_period;
    logic               in_beat;
    logic               div_start;
    logic               div_done;
    logic [PER_W-1:0]   div_rem;
    candle_cmd_t        cmd;
    candle_t            candle;

    assign in_beat = s_tvalid && s_tready;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_ms_reg <= PERIOD_MS_RESET;
        end
        else if (cfg_wr_en)
        begin
            period_ms_reg <= cfg_wr_data;
        end
    end

    // period in ns, registered at the input beat
    assign pms_eff  = (period_ms_reg == '0) ? PMS_W'(1) : period_ms_reg;
    assign per_calc = PER_W'(pms_eff) * PER_W'(NS_PER_MS);

    // input item capture
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            op_reg    <= s_tuser[0];
            ts_reg    <= s_tdata[63:0];
            price_reg <= s_tdata[127:64];
            qty_reg   <= s_tdata[159:128];
            per_reg   <= per_calc;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            started_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            started_reg  <= started_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    // period boundary test against the open candle
    assign ts_diff    = ts_reg - candle.start;
    assign new_period = (ts_reg >= candle.start) && (ts_diff >= TS_W'(per_reg));

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        started_next    = started_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        div_start       = 1'b0;
        cmd.kind        = CMD_NONE;
        cmd.clear_start = '0;
        cmd.price       = price_reg;
        cmd.qty         = qty_reg;
        s_tready        = (state_reg == ST_IDLE);

        // output beat taken
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (op_reg == OP_FLUSH)
                begin
                    if (candle.count != '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.kind   = CMD_CLEAR;
                        state_next = ST_IDLE;
                    end
                end
                else if (!started_reg)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else if (new_period)
                begin
                    if (candle.count != '0)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
                else
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_EMIT:
            begin
                // wait for a free output register
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = candle;
                    if (op_reg == OP_FLUSH)
                    begin
                        cmd.kind   = CMD_CLEAR;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    cmd.kind        = CMD_CLEAR;
                    cmd.clear_start = ts_reg - TS_W'(div_rem);
                    started_next    = 1'b1;
                    state_next      = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.kind   = CMD_TRADE;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    tca_remainder u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (ts_reg),
        .divisor   (per_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    tca_candle_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .candle (candle)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: design/tca_checker.sv
// port-level checks for the trade candle aggregator, bound to the top level
// depends on trade_candle_aggregator ports only
module tca_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [415:0] m_tdata
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // ready drops after every input beat
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after an input beat");

    // an emitted candle always holds trades
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[415:384] != 32'd0)
        else $error("empty candle emitted");

    // open and close lie between low and high
    a_price_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[255:192] <= m_tdata[191:128])
            && (m_tdata[127:64] >= m_tdata[255:192])
            && (m_tdata[127:64] <= m_tdata[191:128])
            && (m_tdata[319:256] >= m_tdata[255:192])
            && (m_tdata[319:256] <= m_tdata[191:128]))
        else $error("candle prices out of order");

endmodule

bind trade_candle_aggregator tca_checker u_tca_checker (.*);
